// ===== rtl/core/truncated_series_product_assert.svh =====
// assertion macros shared by the truncated series product checkers
// needs clk and rst_n in the scope where a macro is used
`ifndef TRUNCATED_SERIES_PRODUCT_ASSERT_SVH
`define TRUNCATED_SERIES_PRODUCT_ASSERT_SVH

// same-cycle implication, held off during reset
`define TSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsp assertion failed");

// next-cycle implication, held off during reset
`define TSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsp assertion failed");

`endif

// ===== rtl/core/tsp_pkg.sv =====
// types and constants for the truncated series product block
// no dependencies
`default_nettype none

package tsp_pkg;

  // number of term pairs the cell row can hold
  localparam int MAX_TERMS = 16;
  // width of a cell index and of the term counter (counter can hold MAX_TERMS)
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  // exact sum of MAX_TERMS 64-bit products needs this many bits
  localparam int ACC_W = 64 + $clog2(MAX_TERMS) + 1;

  localparam logic signed [63:0] C_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] C_MIN = 64'sh8000_0000_0000_0000;

  // input request
  typedef struct packed {
    logic              start_req;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
  } tsp_in_t;

  // result request
  typedef struct packed {
    logic signed [63:0] coef_c;
    logic [3:0]         term_index;
    logic               saturated;
    logic               too_long;
  } tsp_out_t;

  // control shared by every cell of the row
  typedef struct packed {
    logic load;    // store new a, shift new b in at cell 0
    logic rotate;  // move both rings one cell toward cell 0
  } tsp_cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_DRAIN,
    ST_OUT
  } tsp_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsp_cell.sv =====
// one cell of the term row: holds one a term and one reversed b term
// depends on tsp_pkg
`default_nettype none

module tsp_cell (
  input  wire logic                  clk,
  input  wire tsp_pkg::tsp_cell_ctl_t ctl,
  input  wire logic                  a_we,
  input  wire logic signed [31:0]    a_new,
  input  wire logic signed [31:0]    b_shift_in,
  input  wire logic signed [31:0]    a_rot_in,
  input  wire logic signed [31:0]    b_rot_in,
  output logic signed [31:0]         a_q,
  output logic signed [31:0]         b_q
);
  import tsp_pkg::*;

  logic signed [31:0] a_r;
  logic signed [31:0] b_r;

  // load writes a at its own slot and pushes b down the row;
  // rotate walks the whole ring once per term
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (a_we) begin
        a_r <= a_new;
      end
      b_r <= b_shift_in;
    end else if (ctl.rotate) begin
      a_r <= a_rot_in;
      b_r <= b_rot_in;
    end
  end

  assign a_q = a_r;
  assign b_q = b_r;

endmodule

`default_nettype wire

// ===== rtl/core/tsp_mac.sv =====
// shared multiply-accumulate with 64-bit saturation of the exact sum
// depends on tsp_pkg
`default_nettype none

module tsp_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clear,
  input  wire logic               pvld,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      sum_c,
  output logic                    sum_sat
);
  import tsp_pkg::*;

  logic signed [63:0]      prod_r;
  logic                    prod_vld_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-64:0]       acc_top;

  // product stage
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= pvld;
    end
  end

  // accumulate stage, wide enough that it never wraps
  always_ff @(posedge clk) begin
    if (clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{(ACC_W-64){prod_r[63]}}, prod_r};
    end
  end

  // clamp to the signed 64-bit range
  assign acc_top = acc_r[ACC_W-1:63];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      sum_c   = acc_r[63:0];
      sum_sat = 1'b0;
    end else begin
      sum_c   = acc_r[ACC_W-1] ? C_MIN : C_MAX;
      sum_sat = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/truncated_series_product.sv =====
// top level of the truncated series product: sequencer, cell row, shared mac
// depends on tsp_pkg, tsp_cell, tsp_mac
`default_nettype none

// Truncated Cauchy product of two power series. Each input request carries
// term k of A and of B (signed Q16.16); start_req marks term zero and drops
// the stored history. The result request gives term k of the product as
// signed Q32.32, clamped to 64 bits with saturated set when clamping occurs.
// Terms are kept in a row of MAX_TERMS cells: a_j sits in cell j, b is
// shifted in so that cell j holds b_(k-j). A request runs in order: the
// accept edge loads the row, the row then rotates once around its full
// ring feeding cell 0 into a single shared 32x32 multiply-accumulate, the
// drain state empties the product register and the output state writes
// the output register once out_stall lets it. A term past MAX_TERMS is not
// stored, skips the rotation and returns too_long with zero.
// A new request is taken only while the sequencer is idle; a finished
// result may still be waiting on out_stall at that time.
module truncated_series_product (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tsp_pkg::tsp_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tsp_pkg::tsp_out_t      out_data
);
  import tsp_pkg::*;

  tsp_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic               tl_r, tl_nxt;
  logic               out_valid_r;
  tsp_out_t           out_data_r;

  logic               in_fire;
  logic [CNT_W-1:0]   k_new;
  logic               over_cap;
  logic               out_free;
  logic               out_load;
  tsp_cell_ctl_t      cell_ctl;
  logic               mac_clear;
  logic               mac_pvld;
  logic [MAX_TERMS-1:0] a_we;

  logic signed [31:0] a_q [MAX_TERMS];
  logic signed [31:0] b_q [MAX_TERMS];
  logic signed [63:0] sum_c;
  logic               sum_sat;

  // request decode
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign k_new    = in_data.start_req ? '0 : count_r;
  assign over_cap = (k_new == CNT_W'(MAX_TERMS));
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = over_cap ? ST_OUT : ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        if (step_r == IDX_W'(MAX_TERMS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cell_ctl  = '0;
    mac_clear = 1'b0;
    mac_pvld  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cell_ctl.load = in_fire && !over_cap;
        mac_clear     = in_fire;
      end
      ST_ROTATE: begin
        cell_ctl.rotate = 1'b1;
        mac_pvld        = (step_r <= k_r);
      end
      ST_DRAIN: ;
      ST_OUT: out_load = out_free;
      default: ;
    endcase
  end

  // counters and flags
  always_comb begin
    count_nxt = count_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    tl_nxt    = tl_r;
    if (in_fire) begin
      tl_nxt   = over_cap;
      step_nxt = '0;
      if (!over_cap) begin
        count_nxt = k_new + 1'b1;
        k_nxt     = k_new[IDX_W-1:0];
      end
    end else if (state_r == ST_ROTATE) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      k_r     <= '0;
      step_r  <= '0;
      tl_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
      tl_r    <= tl_nxt;
    end
  end

  // a write enable for the cell of the new term
  always_comb begin
    for (int i = 0; i < MAX_TERMS; i++) begin
      a_we[i] = (k_new == CNT_W'(i));
    end
  end

  // cell row, closed into a ring for the walk
  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
    localparam int Nxt = (g + 1) % MAX_TERMS;
    logic signed [31:0] b_in;
    if (g == 0) begin : g_head
      assign b_in = in_data.coef_b;
    end else begin : g_body
      assign b_in = b_q[g-1];
    end
    tsp_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .a_we       (a_we[g]),
      .a_new      (in_data.coef_a),
      .b_shift_in (b_in),
      .a_rot_in   (a_q[Nxt]),
      .b_rot_in   (b_q[Nxt]),
      .a_q        (a_q[g]),
      .b_q        (b_q[g])
    );
  end

  tsp_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (mac_clear),
    .pvld    (mac_pvld),
    .a       (a_q[0]),
    .b       (b_q[0]),
    .sum_c   (sum_c),
    .sum_sat (sum_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (tl_r) begin
        out_data_r.coef_c     <= '0;
        out_data_r.term_index <= '0;
        out_data_r.saturated  <= 1'b0;
        out_data_r.too_long   <= 1'b1;
      end else begin
        out_data_r.coef_c     <= sum_c;
        out_data_r.term_index <= 4'(k_r);
        out_data_r.saturated  <= sum_sat;
        out_data_r.too_long   <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/tsp_checker.sv =====
// port-level checks for the truncated series product, bound to the top level
// depends on tsp_pkg and truncated_series_product_assert.svh
`default_nettype none
`include "truncated_series_product_assert.svh"

module tsp_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire tsp_pkg::tsp_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire tsp_pkg::tsp_out_t out_data
);
  import tsp_pkg::*;

  // an over-length term reports zero with a fixed index
  `TSP_ASSERT_NOW(a_too_long_zero, out_valid && out_data.too_long, out_data.coef_c == 64'sd0 && !out_data.saturated && out_data.term_index == 4'd0)

  // a clamped result sits at one of the range ends
  `TSP_ASSERT_NOW(a_sat_clamped, out_valid && out_data.saturated, out_data.coef_c == C_MAX || out_data.coef_c == C_MIN)

  // an accepted request keeps the block busy for at least the next cycle
  `TSP_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

  // a stalled result holds
  `TSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind truncated_series_product tsp_checker u_tsp_checker (.*);

`default_nettype wire
